// ===== rtl/core/srtf_pkg.sv =====
// ----------------------------------------------------------------------------
// srtf_pkg
// Shared types and fixed field widths of the shortest-remaining-time-first
// schedule simulator.
// ----------------------------------------------------------------------------
`default_nettype none

package srtf_pkg;

  localparam int ID_W      = 16;
  localparam int IN_TIME_W = 16;
  localparam int WAIT_W    = 20;
  localparam int TOTAL_W   = 24;

  typedef struct packed {
    logic [ID_W-1:0]      process_id;
    logic [IN_TIME_W-1:0] arrival_time;
    logic [IN_TIME_W-1:0] burst_time;
    logic                 last_process;
  } srtf_in_t;

  typedef struct packed {
    logic [ID_W-1:0]    result_id;
    logic [WAIT_W-1:0]  waiting_time;
    logic [WAIT_W-1:0]  turnaround_time;
    logic [TOTAL_W-1:0] total_waiting;
    logic [TOTAL_W-1:0] total_turnaround;
    logic               last_result;
  } srtf_out_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_CHECK,
    ST_SCAN,
    ST_SCAN_END,
    ST_STEP,
    ST_ADV,
    ST_FIN,
    ST_EMIT_RD,
    ST_EMIT_CALC,
    ST_EMIT_PUSH
  } srtf_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/srtf_table.sv =====
// ----------------------------------------------------------------------------
// srtf_table
// Process table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_table #(
  parameter int DEPTH  = 8,
  parameter int DATA_W = 8,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [AW-1:0]            wr_addr,
  input  wire logic [DATA_W-1:0]        wr_data,
  input  wire logic                     rd_en,
  input  wire logic [AW-1:0]            rd_addr,
  output logic      [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/srtf_out_reg.sv =====
// ----------------------------------------------------------------------------
// srtf_out_reg
// Result register between the sequencer and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_out_reg
  import srtf_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  input  wire srtf_out_t push_data,
  output logic           push_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  output srtf_out_t      out_data
);

  logic      vld_r;
  logic      vld_nxt;
  srtf_out_t data_r;

  assign push_ready = !vld_r || out_ready;
  assign out_valid  = vld_r;
  assign out_data   = data_r;

  always_comb begin
    vld_nxt = vld_r;
    if (push_valid && push_ready) begin
      vld_nxt = 1'b1;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_valid && push_ready) begin
      data_r <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/srtf_ctrl.sv =====
// ----------------------------------------------------------------------------
// srtf_ctrl
// Sequencer: loads the table, scans it once per scheduling event, advances
// time to the next arrival or completion, and reads out the results.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_ctrl
  import srtf_pkg::*;
#(
  parameter int MAX_PROCS = 8,
  parameter int TIME_BITS = 16,
  localparam int TW       = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W,
  localparam int IDX_W    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1,
  localparam int ENT_W    = ID_W + 3 * TW + WAIT_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire srtf_in_t          in_data,
  output logic                   push_valid,
  output srtf_out_t              push_data,
  input  wire logic              push_ready,
  output logic                   mem_wr_en,
  output logic [IDX_W-1:0]       mem_wr_addr,
  output logic [ENT_W-1:0]       mem_wr_data,
  output logic                   mem_rd_en,
  output logic [IDX_W-1:0]       mem_rd_addr,
  input  wire logic [ENT_W-1:0]  mem_rd_data
);

  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int TICK_W = TW + CNT_W;
  localparam logic [TW:0]      NONE  = {(TW + 1){1'b1}};
  localparam logic [CNT_W-1:0] FULL  = CNT_W'(MAX_PROCS);

  srtf_state_t state_r, state_nxt;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   done_r, done_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [TW:0]        min_r, min_nxt;
  logic [TW:0]        next_r, next_nxt;
  logic [IDX_W-1:0]   pick_r, pick_nxt;
  logic               chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]   chk_idx_r, chk_idx_nxt;
  logic [TOTAL_W-1:0] tw_r, tw_nxt;
  logic [TOTAL_W-1:0] tt_r, tt_nxt;

  logic [ID_W-1:0]    pk_id_r, pk_id_nxt;
  logic [TW-1:0]      pk_arr_r, pk_arr_nxt;
  logic [TW-1:0]      pk_burst_r, pk_burst_nxt;
  logic [TW-1:0]      pk_rem_r, pk_rem_nxt;
  logic [TW-1:0]      run_r, run_nxt;
  logic [TW:0]        need_r, need_nxt;
  logic [ID_W-1:0]    em_id_r, em_id_nxt;
  logic [WAIT_W-1:0]  em_w_r, em_w_nxt;
  logic [WAIT_W-1:0]  em_t_r, em_t_nxt;
  logic               em_last_r, em_last_nxt;

  logic [ID_W-1:0]    rd_id;
  logic [TW-1:0]      rd_arr, rd_burst, rd_rem;
  logic [WAIT_W-1:0]  rd_wait;
  logic               arrived, cand, fut;
  logic [TICK_W-1:0]  gap;
  logic [TICK_W-1:0]  need_ext;
  logic [WAIT_W-1:0]  fin_wait;
  logic [TW-1:0]      ld_arr, ld_burst;
  logic               in_xfer;

  assign rd_id    = mem_rd_data[ENT_W-1 -: ID_W];
  assign rd_arr   = mem_rd_data[WAIT_W+3*TW-1 -: TW];
  assign rd_burst = mem_rd_data[WAIT_W+2*TW-1 -: TW];
  assign rd_rem   = mem_rd_data[WAIT_W+TW-1 -: TW];
  assign rd_wait  = mem_rd_data[WAIT_W-1:0];

  assign ld_arr   = in_data.arrival_time[TW-1:0];
  assign ld_burst = in_data.burst_time[TW-1:0];
  assign in_xfer  = in_valid && in_ready;

  // scan compare on the entry returned by the table
  assign arrived = TICK_W'(rd_arr) <= tick_r;
  assign cand    = arrived && (rd_rem != '0) && ({1'b0, rd_rem} < min_r);
  assign fut     = !arrived && (rd_rem != '0) && ({1'b0, rd_arr} < next_r);

  assign gap      = TICK_W'(next_r[TW-1:0]) - tick_r;
  assign need_ext = TICK_W'(need_r);
  assign fin_wait = (tick_r >= need_ext) ? WAIT_W'(tick_r - need_ext) : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (in_xfer && in_data.last_process) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = (done_r == count_r) ? ST_EMIT_RD : ST_SCAN;
      end
      ST_SCAN: begin
        if (idx_r == count_r - 1'b1) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: state_nxt = ST_STEP;
      ST_STEP: begin
        if (min_r != NONE) begin
          state_nxt = ST_ADV;
        end else if (next_r == NONE) begin
          state_nxt = ST_EMIT_RD;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_ADV:       state_nxt = ST_FIN;
      ST_FIN:       state_nxt = ST_CHECK;
      ST_EMIT_RD:   state_nxt = ST_EMIT_CALC;
      ST_EMIT_CALC: state_nxt = ST_EMIT_PUSH;
      ST_EMIT_PUSH: begin
        if (push_ready) begin
          state_nxt = em_last_r ? ST_LOAD : ST_EMIT_RD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ready     = 1'b0;
    push_valid   = 1'b0;
    push_data    = '0;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = '0;
    mem_wr_data  = '0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = idx_r[IDX_W-1:0];

    count_nxt    = count_r;
    done_nxt     = done_r;
    idx_nxt      = idx_r;
    tick_nxt     = tick_r;
    min_nxt      = min_r;
    next_nxt     = next_r;
    pick_nxt     = pick_r;
    chk_vld_nxt  = 1'b0;
    chk_idx_nxt  = idx_r[IDX_W-1:0];
    tw_nxt       = tw_r;
    tt_nxt       = tt_r;
    pk_id_nxt    = pk_id_r;
    pk_arr_nxt   = pk_arr_r;
    pk_burst_nxt = pk_burst_r;
    pk_rem_nxt   = pk_rem_r;
    run_nxt      = run_r;
    need_nxt     = need_r;
    em_id_nxt    = em_id_r;
    em_w_nxt     = em_w_r;
    em_t_nxt     = em_t_r;
    em_last_nxt  = em_last_r;

    // candidates of the running scan, the entry of the previous read
    if (chk_vld_r) begin
      if (cand) begin
        min_nxt      = {1'b0, rd_rem};
        pick_nxt     = chk_idx_r;
        pk_id_nxt    = rd_id;
        pk_arr_nxt   = rd_arr;
        pk_burst_nxt = rd_burst;
        pk_rem_nxt   = rd_rem;
      end
      if (fut) begin
        next_nxt = {1'b0, rd_arr};
      end
    end

    unique case (state_r)
      ST_LOAD: begin
        in_ready = 1'b1;
        if (in_xfer && (count_r < FULL)) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = count_r[IDX_W-1:0];
          mem_wr_data = {in_data.process_id, ld_arr, ld_burst, ld_burst, {WAIT_W{1'b0}}};
          count_nxt   = count_r + 1'b1;
          if (ld_burst == '0) begin
            done_nxt = done_r + 1'b1;
          end
        end
      end
      ST_CHECK: begin
        idx_nxt  = '0;
        next_nxt = NONE;
      end
      ST_SCAN: begin
        mem_rd_en   = 1'b1;
        chk_vld_nxt = 1'b1;
        idx_nxt     = idx_r + 1'b1;
      end
      ST_SCAN_END: begin
      end
      ST_STEP: begin
        if (min_r == NONE) begin
          // idle: jump to the next arrival
          tick_nxt = TICK_W'(next_r[TW-1:0]);
        end else begin
          // run the pick until it finishes or the next arrival
          run_nxt  = ((next_r != NONE) && (gap < TICK_W'(pk_rem_r))) ?
                     gap[TW-1:0] : pk_rem_r;
          need_nxt = {1'b0, pk_burst_r} + {1'b0, pk_arr_r};
        end
      end
      ST_ADV: begin
        tick_nxt   = tick_r + TICK_W'(run_r);
        pk_rem_nxt = pk_rem_r - run_r;
      end
      ST_FIN: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = pick_r;
        if (pk_rem_r == '0) begin
          mem_wr_data = {pk_id_r, pk_arr_r, pk_burst_r, pk_rem_r, fin_wait};
          done_nxt    = done_r + 1'b1;
          min_nxt     = NONE;
        end else begin
          mem_wr_data = {pk_id_r, pk_arr_r, pk_burst_r, pk_rem_r, {WAIT_W{1'b0}}};
          min_nxt     = {1'b0, pk_rem_r};
        end
      end
      ST_EMIT_RD: begin
        mem_rd_en = 1'b1;
      end
      ST_EMIT_CALC: begin
        em_id_nxt   = rd_id;
        em_w_nxt    = rd_wait;
        em_t_nxt    = WAIT_W'(rd_burst) + rd_wait;
        em_last_nxt = (idx_r == count_r - 1'b1);
      end
      ST_EMIT_PUSH: begin
        push_valid                = 1'b1;
        push_data.result_id       = em_id_r;
        push_data.waiting_time    = em_w_r;
        push_data.turnaround_time = em_t_r;
        push_data.total_waiting   = tw_r + TOTAL_W'(em_w_r);
        push_data.total_turnaround = tt_r + TOTAL_W'(em_t_r);
        push_data.last_result     = em_last_r;
        if (push_ready) begin
          tw_nxt  = push_data.total_waiting;
          tt_nxt  = push_data.total_turnaround;
          idx_nxt = idx_r + 1'b1;
          if (em_last_r) begin
            // batch done, back to reset values
            count_nxt = '0;
            done_nxt  = '0;
            tick_nxt  = '0;
            min_nxt   = NONE;
            pick_nxt  = '0;
            tw_nxt    = '0;
            tt_nxt    = '0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      done_r    <= '0;
      idx_r     <= '0;
      tick_r    <= '0;
      min_r     <= NONE;
      next_r    <= NONE;
      pick_r    <= '0;
      chk_vld_r <= 1'b0;
      tw_r      <= '0;
      tt_r      <= '0;
      em_last_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      done_r    <= done_nxt;
      idx_r     <= idx_nxt;
      tick_r    <= tick_nxt;
      min_r     <= min_nxt;
      next_r    <= next_nxt;
      pick_r    <= pick_nxt;
      chk_vld_r <= chk_vld_nxt;
      tw_r      <= tw_nxt;
      tt_r      <= tt_nxt;
      em_last_r <= em_last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    pk_id_r    <= pk_id_nxt;
    pk_arr_r   <= pk_arr_nxt;
    pk_burst_r <= pk_burst_nxt;
    pk_rem_r   <= pk_rem_nxt;
    run_r      <= run_nxt;
    need_r     <= need_nxt;
    em_id_r    <= em_id_nxt;
    em_w_r     <= em_w_nxt;
    em_t_r     <= em_t_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/srtf_schedule_simulator.sv =====
// ----------------------------------------------------------------------------
// srtf_schedule_simulator
// Preemptive shortest-remaining-time-first schedule simulator.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one process per transfer (id, arrival tick, burst). Loading takes
//           one transfer per cycle. Entries past MAX_PROCS are dropped; the
//           transfer with last_process set starts the simulation.
//   out_* : one result per loaded process, in load order, with running
//           totals; last_result marks the final one of the batch.
// Operation, with N loaded processes:
//   the simulation runs event by event (each arrival or completion), one
//   table scan per event: ST_CHECK, ST_SCAN, ST_SCAN_END, ST_STEP, then
//   ST_ADV and ST_FIN when a process runs; at most 2N events. The scan is
//   bound by the single read port of the process table.
//   readout goes EMIT_RD, EMIT_CALC, EMIT_PUSH per result, one at a time.
//   in_ready is low from the last load until the last result has been handed
//   to the output register.
// Reset clears the batch state; the table needs no clearing.
// A stalled receiver holds the output register and the readout waits on it;
// nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_schedule_simulator
  import srtf_pkg::*;
#(
  parameter int MAX_PROCS = 8,
  parameter int TIME_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire srtf_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output srtf_out_t      out_data
);

  localparam int TW    = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;
  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int ENT_W = ID_W + 3 * TW + WAIT_W;

  logic             push_valid;
  logic             push_ready;
  srtf_out_t        push_data;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  logic [ENT_W-1:0] mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  logic [ENT_W-1:0] mem_rd_data;

  srtf_ctrl #(
    .MAX_PROCS (MAX_PROCS),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .push_valid  (push_valid),
    .push_data   (push_data),
    .push_ready  (push_ready),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data)
  );

  srtf_table #(
    .DEPTH  (MAX_PROCS),
    .DATA_W (ENT_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  srtf_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

`default_nettype wire

// ===== rtl/core/srtf_checker.sv =====
// ----------------------------------------------------------------------------
// srtf_checker
// Port-level checks of the schedule simulator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_checker
  import srtf_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire srtf_in_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire srtf_out_t out_data
);

  // no result survives reset
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // loading stops once the batch is closed
  a_last_closes_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.last_process |=> !in_ready)
    else $error("in_ready high right after last process");

  // while a batch is still being read out no new process is taken
  a_no_load_midbatch: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_result |-> !in_ready)
    else $error("in_ready high during readout");

endmodule

bind srtf_schedule_simulator srtf_checker u_srtf_checker (.*);

`default_nettype wire

// ===== dv/srtf_schedule_checker.sv =====
// ----------------------------------------------------------------------------
// srtf_schedule_checker
// Watches both channels of the schedule simulator. Each accepted process within
// MAX_PROCS is stored; a transfer with last_process set runs a shortest-remaining-time-first
// prediction of the stored batch. Results are compared in order, field by field.
// ----------------------------------------------------------------------------
module srtf_schedule_checker
  import srtf_pkg::*;
#(
  parameter int MAX_PROCS = 8,
  parameter int TIME_BITS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  input  wire logic in_ready,
  input  srtf_in_t  in_data,
  input  wire logic out_valid,
  input  wire logic out_ready,
  input  srtf_out_t out_data,
  output int        fail_count,
  output int        pending,
  output int        results_checked
);

  localparam longint unsigned NONE       = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam longint unsigned TIME_MASK  = (64'd1 << TIME_BITS) - 1;
  localparam longint unsigned WAIT_MASK  = (64'd1 << WAIT_W) - 1;

  logic [ID_W-1:0]  id_tab    [MAX_PROCS];
  longint unsigned  arr_tab   [MAX_PROCS];
  longint unsigned  burst_tab [MAX_PROCS];
  int               loaded;
  int               fails;
  int               checked;
  srtf_out_t        sched_q [$];

  // run the stored batch to completion and queue one result per process
  function automatic void schedule_batch();
    longint unsigned left   [MAX_PROCS];
    longint unsigned waited [MAX_PROCS];
    longint unsigned now, best, next_arr, span, need, turn, wsum, tsum;
    int              pick, finished, j;
    bit              stuck;
    srtf_out_t       res;
    now = 0;
    best = NONE;
    pick = 0;
    finished = 0;
    stuck = 1'b0;
    for (j = 0; j < loaded; j++) begin
      left[j] = burst_tab[j];
      waited[j] = 0;
      if (burst_tab[j] == 0) finished++;
    end
    while (finished < loaded && !stuck) begin
      // strict compare keeps the running process on a tie
      for (j = 0; j < loaded; j++) begin
        if (arr_tab[j] <= now && left[j] > 0 && left[j] < best) begin
          best = left[j];
          pick = j;
        end
      end
      next_arr = NONE;
      for (j = 0; j < loaded; j++) begin
        if (left[j] > 0 && arr_tab[j] > now && arr_tab[j] < next_arr) next_arr = arr_tab[j];
      end
      if (best == NONE) begin
        if (next_arr == NONE) stuck = 1'b1;
        else now = next_arr;
      end else begin
        // the pick cannot change before its completion or the next arrival
        span = left[pick];
        if (next_arr != NONE && next_arr - now < span) span = next_arr - now;
        left[pick] -= span;
        now += span;
        best = left[pick];
        if (best == 0) begin
          need = burst_tab[pick] + arr_tab[pick];
          waited[pick] = (now >= need) ? now - need : 0;
          best = NONE;
          finished++;
        end
      end
    end
    wsum = 0;
    tsum = 0;
    for (j = 0; j < loaded; j++) begin
      turn = (burst_tab[j] + (waited[j] & WAIT_MASK)) & WAIT_MASK;
      wsum += waited[j] & WAIT_MASK;
      tsum += turn;
      res.result_id        = id_tab[j];
      res.waiting_time     = WAIT_W'(waited[j]);
      res.turnaround_time  = WAIT_W'(turn);
      res.total_waiting    = TOTAL_W'(wsum);
      res.total_turnaround = TOTAL_W'(tsum);
      res.last_result      = (j == loaded - 1);
      sched_q.push_back(res);
    end
  endfunction

  function automatic bit field_bad(string fname, logic [ID_W-1:0] rid,
                                   logic [TOTAL_W-1:0] want, logic [TOTAL_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s of process %0h expected %0h, got %0h", $time, fname, rid, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk) begin : watch
    srtf_out_t want;
    bit        bad;
    if (!rst_n) begin
      loaded = 0;
      sched_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        checked++;
        if (sched_q.size() == 0) begin
          $display("%0t: result with no process waiting, expected nothing, got %0h",
                   $time, out_data);
          fails++;
        end else begin
          want = sched_q.pop_front();
          bad = 1'b0;
          bad |= field_bad("result_id", want.result_id, TOTAL_W'(want.result_id),
                           TOTAL_W'(out_data.result_id));
          bad |= field_bad("waiting_time", want.result_id, TOTAL_W'(want.waiting_time),
                           TOTAL_W'(out_data.waiting_time));
          bad |= field_bad("turnaround_time", want.result_id,
                           TOTAL_W'(want.turnaround_time),
                           TOTAL_W'(out_data.turnaround_time));
          bad |= field_bad("total_waiting", want.result_id, want.total_waiting,
                           out_data.total_waiting);
          bad |= field_bad("total_turnaround", want.result_id, want.total_turnaround,
                           out_data.total_turnaround);
          bad |= field_bad("last_result", want.result_id, TOTAL_W'(want.last_result),
                           TOTAL_W'(out_data.last_result));
          if (bad) fails++;
        end
      end
      if (in_valid && in_ready) begin
        // entries past the table size are dropped
        if (loaded < MAX_PROCS) begin
          id_tab[loaded]    = in_data.process_id;
          arr_tab[loaded]   = in_data.arrival_time & TIME_MASK;
          burst_tab[loaded] = in_data.burst_time & TIME_MASK;
          loaded++;
        end
        if (in_data.last_process) begin
          schedule_batch();
          loaded = 0;
        end
      end
    end
    fail_count      <= fails;
    pending         <= sched_q.size();
    results_checked <= checked;
  end

endmodule

// ===== dv/tb_srtf_schedule_simulator.sv =====
// ----------------------------------------------------------------------------
// tb_srtf_schedule_simulator
// Offers batches of processes to the schedule simulator: a directed set of
// corner cases, then random batches with random gaps and output stalls,
// including long output holds. The checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_srtf_schedule_simulator;
  import srtf_pkg::*;

  localparam int  PROCS       = 8;
  localparam int  TBITS       = 16;
  localparam int  RANDOM_PROCS = 128;
  localparam int  HOLD_CYCLES = 600;
  localparam int  DRAIN_CYCLES = 50;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  srtf_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  srtf_out_t out_data;

  int fail_count;
  int pending;
  int results_checked;
  int procs_offered = 0;
  int batches = 0;
  int hold_requests = 0;
  bit steady = 1'b0;

  srtf_schedule_simulator #(
    .MAX_PROCS(PROCS),
    .TIME_BITS(TBITS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  srtf_schedule_checker #(
    .MAX_PROCS(PROCS),
    .TIME_BITS(TBITS)
  ) checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .fail_count     (fail_count),
    .pending        (pending),
    .results_checked(results_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver: random ready with occasional long holds on request
  initial begin : receiver
    int served;
    int span;
    served = 0;
    @(posedge clk);
    forever begin
      if (served < hold_requests) begin
        served++;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (steady || $urandom_range(0, 99) < 60) begin
        out_ready <= 1'b1;
        span = steady ? 1 : $urandom_range(1, 12);
        repeat (span) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        span = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
        repeat (span) @(posedge clk);
      end
    end
  end

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic offer_proc(input logic [15:0] pid, input logic [15:0] arr,
                            input logic [15:0] burst, input logic last);
    int gap;
    in_data <= '{process_id: pid, arrival_time: arr, burst_time: burst, last_process: last};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    procs_offered++;
    if (last) batches++;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // mostly short arrivals and bursts so processes compete; a few full-range
  task automatic send_random_batch(input int count);
    logic [15:0] arr;
    logic [15:0] burst;
    int          k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        arr   = 16'($urandom_range(0, 16'hFFFF));
        burst = 16'($urandom_range(0, 16'hFFFF));
      end else begin
        arr   = 16'($urandom_range(0, 40));
        burst = ($urandom_range(0, 99) < 15) ? 16'd0 : 16'($urandom_range(1, 25));
      end
      offer_proc(16'($urandom_range(0, 16'hFFFF)), arr, burst, k == count - 1);
    end
  endtask

  initial begin : stimulus
    int random_sent;
    int count;
    int k;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // lone zero burst, then lone extreme process
    offer_proc(16'h0000, 16'h0000, 16'h0000, 1'b1);
    offer_proc(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    // preemption by a shorter arrival
    offer_proc(16'd1, 16'd0, 16'd8, 1'b0);
    offer_proc(16'd2, 16'd1, 16'd4, 1'b0);
    offer_proc(16'd3, 16'd2, 16'd9, 1'b0);
    offer_proc(16'd4, 16'd3, 16'd5, 1'b1);
    // tie at start goes to lower index; equal remaining does not preempt
    offer_proc(16'd5, 16'd0, 16'd3, 1'b0);
    offer_proc(16'd6, 16'd0, 16'd3, 1'b0);
    offer_proc(16'd7, 16'd1, 16'd2, 1'b1);
    // zero burst among others and an idle stretch before a late arrival
    offer_proc(16'd8, 16'd0, 16'd2, 1'b0);
    offer_proc(16'd9, 16'd1, 16'd0, 1'b0);
    offer_proc(16'd10, 16'd50, 16'd3, 1'b1);
    // table overflow: two dropped entries, the dropped last one still starts
    for (k = 0; k < 10; k++) begin
      offer_proc(16'hA000 | 16'(k), (k == 3) ? 16'hFFFF : 16'(k * 7),
                 (k == 1 || k == 6) ? 16'hFFFF : 16'(k * 3 + 1), k == 9);
    end

    random_sent = 0;
    k = 0;
    while (random_sent < RANDOM_PROCS) begin
      count = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      steady = (k >= 8 && k < 12);
      // long output hold, then a second batch offered while the block is full
      if (k == 4 || k == 16) begin
        hold_requests++;
        send_random_batch(PROCS);
        send_random_batch(3);
        random_sent += PROCS + 3;
      end else begin
        send_random_batch(count);
        random_sent += count;
      end
      k++;
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d batches of %0d processes in all, %0d results compared",
             batches, procs_offered, results_checked);
    $display("zero bursts, ties, preemption, idle gaps, dropped entries, long output holds");
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
